>>> hw/rtl/qdd_pkg.sv
// Package for the quadrature detent decoder: item and result types, op codes,
// register map constants and the Gray transition table. No dependencies.
`default_nettype none

package qdd_pkg;

  localparam int unsigned StepsW    = 7;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 8;

  localparam logic [StepsW-1:0]    StepsReset    = 7'd4;
  localparam logic [IntervalW-1:0] IntervalReset = 10'd1;
  localparam logic [StepsW-1:0]    DetentMin     = 7'd1;
  localparam logic [StepsW-1:0]    DetentMax     = 7'd64;

  // Register index, taken from paddr[2]
  localparam logic RegSteps    = 1'b0;
  localparam logic RegInterval = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SEED   = 2'd1,
    OP_TAKE   = 2'd2
  } op_e;

  typedef struct packed {
    logic [StepsW-1:0]    steps_per_detent;
    logic [IntervalW-1:0] sample_interval;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] time_ms;
    logic [1:0]       phase;
  } item_t;

  typedef struct packed {
    logic signed [CountW-1:0] pending_now;
    logic signed [CountW-1:0] taken_turns;
  } result_t;

  // Quarter-step delta for {previous phase, current phase}
  function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default:                 d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qdd_regs.sv
// APB-style configuration registers for the quadrature detent decoder.
// Depends on qdd_pkg.
`default_nettype none

module qdd_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output qdd_pkg::cfg_t     cfg_o
);

  logic [qdd_pkg::StepsW-1:0]    steps_q;
  logic [qdd_pkg::IntervalW-1:0] interval_q;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q    <= qdd_pkg::StepsReset;
      interval_q <= qdd_pkg::IntervalReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        qdd_pkg::RegSteps:    steps_q    <= pwdata[qdd_pkg::StepsW-1:0];
        qdd_pkg::RegInterval: interval_q <= pwdata[qdd_pkg::IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      qdd_pkg::RegSteps:    prdata = {25'd0, steps_q};
      qdd_pkg::RegInterval: prdata = {22'd0, interval_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o.steps_per_detent = steps_q;
  assign cfg_o.sample_interval  = interval_q;

endmodule

`default_nettype wire

>>> hw/rtl/qdd_step.sv
// Decoder state and the combinational update for one item: time gate, Gray
// lookup, quarter-step accumulation and saturating detent count. Uses qdd_pkg.
`default_nettype none

module qdd_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  qdd_pkg::item_t       item_i,
  input  qdd_pkg::cfg_t        cfg_i,
  output qdd_pkg::result_t     res_o
);

  logic [1:0]                          last_phase_q, last_phase_d;
  logic [qdd_pkg::TimeW-1:0]           last_time_q, last_time_d;
  logic signed [qdd_pkg::CountW-1:0]   acc_q, acc_d;
  logic signed [qdd_pkg::CountW-1:0]   pending_q, pending_d;
  logic signed [qdd_pkg::CountW-1:0]   taken;
  logic [qdd_pkg::StepsW-1:0]          size;
  logic signed [qdd_pkg::CountW:0]     size_s;
  logic signed [qdd_pkg::CountW:0]     acc_sum;
  logic signed [1:0]                   delta;
  logic [qdd_pkg::TimeW-1:0]           diff;

  always_comb begin
    if (cfg_i.steps_per_detent < qdd_pkg::DetentMin) begin
      size = qdd_pkg::DetentMin;
    end else if (cfg_i.steps_per_detent > qdd_pkg::DetentMax) begin
      size = qdd_pkg::DetentMax;
    end else begin
      size = cfg_i.steps_per_detent;
    end
    size_s  = $signed({2'b00, size});
    diff    = item_i.time_ms - last_time_q;
    delta   = qdd_pkg::gray_delta({last_phase_q, item_i.phase});
    acc_sum = $signed({acc_q[qdd_pkg::CountW-1], acc_q})
            + $signed({{(qdd_pkg::CountW-1){delta[1]}}, delta});

    last_phase_d = last_phase_q;
    last_time_d  = last_time_q;
    acc_d        = acc_q;
    pending_d    = pending_q;
    taken        = '0;

    unique case (item_i.op)
      qdd_pkg::OP_SAMPLE: begin
        // signed wrap-around difference, rejected when negative or too soon
        if (!diff[qdd_pkg::TimeW-1] && diff >= {22'd0, cfg_i.sample_interval}) begin
          last_time_d  = item_i.time_ms;
          last_phase_d = item_i.phase;
          acc_d        = acc_sum[qdd_pkg::CountW-1:0];
          if (acc_sum >= size_s) begin
            acc_d = 8'(acc_sum - size_s);
            if (pending_q != 8'sd127) pending_d = pending_q + 8'sd1;
          end else if (acc_sum <= -size_s) begin
            acc_d = 8'(acc_sum + size_s);
            if (pending_q != -8'sd128) pending_d = pending_q - 8'sd1;
          end
        end
      end
      qdd_pkg::OP_SEED: begin
        last_phase_d = item_i.phase;
        last_time_d  = item_i.time_ms - {22'd0, cfg_i.sample_interval};
      end
      qdd_pkg::OP_TAKE: begin
        taken     = pending_q;
        pending_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= '0;
      last_time_q  <= '0;
      acc_q        <= '0;
      pending_q    <= '0;
    end else if (fire_i) begin
      last_phase_q <= last_phase_d;
      last_time_q  <= last_time_d;
      acc_q        <= acc_d;
      pending_q    <= pending_d;
    end
  end

  assign res_o.taken_turns = taken;
  assign res_o.pending_now = pending_d;

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= 8'sd63 && acc_q >= -8'sd63)
    else $error("quarter accumulator out of range");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.op == qdd_pkg::OP_TAKE |=> pending_q == 8'sd0)
    else $error("take did not clear pending count");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(pending_q) && $stable(acc_q) && $stable(last_time_q))
    else $error("state moved without an item");

endmodule

`default_nettype wire

>>> hw/rtl/quadrature_detent_decoder_core.sv
// Quadrature detent decoder: takes one item per clock (op in tuser, timestamp
// and phase in tdata) and returns one result per item; after its transfer the item
// goes through an input register, then the state update in qdd_step feeding the
// output register. Sustained rate is one item per cycle while the output side
// keeps taking; a stalled output backs up through both registers.
// Configuration goes through qdd_regs at addresses 0x0 (steps_per_detent) and
// 0x4 (sample_interval). Uses qdd_pkg, qdd_regs and qdd_step.
`default_nettype none

module quadrature_detent_decoder_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,   // [31:0] time_ms, [33:32] phase, rest zero
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [15:0]  m_axis_tdata,   // [7:0] taken_turns, [15:8] pending_now
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  qdd_pkg::cfg_t    cfg;
  qdd_pkg::item_t   in_q;
  qdd_pkg::result_t res;
  qdd_pkg::result_t out_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer;
  logic             adv;

  qdd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer)  in_valid_d = 1'b1;
    else if (adv) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (adv)                out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.op      <= qdd_pkg::op_e'(s_axis_tuser);
      in_q.time_ms <= s_axis_tdata[31:0];
      in_q.phase   <= s_axis_tdata[33:32];
    end
    if (adv) out_q <= res;
  end

  qdd_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.pending_now, out_q.taken_turns};

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input held off without a stalled output");

  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("processed item did not reach the output register");

endmodule

`default_nettype wire

>>> tb/detent_checker.sv
// Checker for quadrature_detent_decoder_core: follows APB writes and both stream
// channels, predicts each result from the accepted items and compares it.
// Depends on qdd_pkg for the item, result and register definitions.
`default_nettype none

module detent_checker
  import qdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [39:0] s_tdata_i,   // [31:0] time_ms, [33:32] phase
  input  wire logic [1:0]  s_tuser_i,   // [1:0] op
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [15:0] m_tdata_i,   // [7:0] taken_turns, [15:8] pending_now
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic        pready_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output int unsigned      mismatches_o,
  output int unsigned      outstanding_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int          CountMax    = 127;
  localparam int          CountMin    = -128;

  logic [StepsW-1:0]    steps_q      = StepsReset;
  logic [IntervalW-1:0] interval_q   = IntervalReset;
  logic [1:0]           prev_phase   = '0;
  logic [TimeW-1:0]     prev_time    = '0;
  int                   quarter_sum  = 0;
  int                   pending_turns = 0;
  result_t              expected_counts [$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  // Forward rotation runs 0 -> 2 -> 3 -> 1 -> 0 (A is bit 1, B is bit 0)
  function automatic int quarter_step(input logic [1:0] from, input logic [1:0] to);
    int d;
    case ({from, to})
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: d = 1;
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: d = -1;
      default: d = 0;
    endcase
    return d;
  endfunction

  task automatic decode_item(input logic [1:0] op, input logic [TimeW-1:0] t,
                             input logic [1:0] ph, output result_t res);
    logic [TimeW-1:0] elapsed;
    int size;
    res = '0;
    if (op == OP_SAMPLE) begin
      elapsed = t - prev_time;
      if (!elapsed[TimeW-1] && elapsed >= interval_q) begin
        if (steps_q < DetentMin) size = int'(DetentMin);
        else if (steps_q > DetentMax) size = int'(DetentMax);
        else size = int'(steps_q);
        prev_time = t;
        quarter_sum += quarter_step(prev_phase, ph);
        prev_phase = ph;
        // detent is consumed even when the pending count is pinned
        if (quarter_sum >= size) begin
          if (pending_turns < CountMax) pending_turns++;
          quarter_sum -= size;
        end else if (quarter_sum <= -size) begin
          if (pending_turns > CountMin) pending_turns--;
          quarter_sum += size;
        end
      end
    end else if (op == OP_SEED) begin
      prev_phase = ph;
      prev_time  = t - interval_q;
    end else if (op == OP_TAKE) begin
      res.taken_turns = pending_turns[CountW-1:0];
      pending_turns   = 0;
    end
    res.pending_now = pending_turns[CountW-1:0];
  endtask

  always @(posedge clk_i) begin : track
    result_t want;
    result_t got;
    if (!rst_ni) begin
      steps_q       = StepsReset;
      interval_q    = IntervalReset;
      prev_phase    = '0;
      prev_time     = '0;
      quarter_sum   = 0;
      pending_turns = 0;
      expected_counts.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == RegSteps) steps_q = pwdata_i[StepsW-1:0];
        else interval_q = pwdata_i[IntervalW-1:0];
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (expected_counts.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit)
            $display("unexpected result: taken_turns %0d pending_now %0d",
                     got.taken_turns, got.pending_now);
        end else begin
          want = expected_counts.pop_front();
          if (got.taken_turns !== want.taken_turns || got.pending_now !== want.pending_now)
          begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit)
              $display("result differs: taken_turns exp %0d got %0d, pending_now exp %0d got %0d",
                       want.taken_turns, got.taken_turns, want.pending_now, got.pending_now);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_item(s_tuser_i, s_tdata_i[TimeW-1:0], s_tdata_i[TimeW+1:TimeW], want);
        expected_counts.push_back(want);
      end
      outstanding_o = expected_counts.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Top of the quadrature detent decoder testbench: clock, reset, APB setup,
// directed and random item streams with random idling, watchdog and verdict.
// Depends on qdd_pkg, quadrature_detent_decoder_core and detent_checker.
`default_nettype none

module testbench;
  import qdd_pkg::*;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam logic [2:0]  AddrSteps    = {RegSteps, 2'b00};
  localparam logic [2:0]  AddrInterval = {RegInterval, 2'b00};
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned MaxIdle      = 18;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [31:0] time_ms, [33:32] phase, rest zero
  logic [1:0]  s_axis_tuser;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] taken_turns, [15:8] pending_now
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned          mismatch_count;
  int unsigned          results_due;
  bit                   no_idle = 1'b0;
  logic [IntervalW-1:0] cfg_interval = IntervalReset;

  always #1 clk_i = ~clk_i;

  quadrature_detent_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  detent_checker detent_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatch_count),
    .outstanding_o (results_due)
  );

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // upper data bits are random; the block keeps only the register width
  task automatic configure(input logic [StepsW-1:0] steps, input logic [IntervalW-1:0] interval);
    logic [31:0] data;
    data = $urandom();
    data[StepsW-1:0] = steps;
    write_reg(AddrSteps, data);
    data = $urandom();
    data[IntervalW-1:0] = interval;
    write_reg(AddrInterval, data);
    cfg_interval = interval;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [TimeW-1:0] t, input logic [1:0] ph);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {6'b0, ph, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  // Mostly clean rotation with occasional direction flips, plus early, stale,
  // glitched, reseeded and unused-op items mixed in.
  task automatic run_phase(input logic [StepsW-1:0] steps, input logic [IntervalW-1:0] interval,
                           input int unsigned take_pct, input int unsigned flip_pct,
                           input int dir, input logic [TimeW-1:0] start_t,
                           input int unsigned count);
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] s;
    logic [1:0]       ph;
    int               d;
    int unsigned      r;
    settle();
    configure(steps, interval);
    d  = dir;
    ph = 2'($urandom_range(0, 3));
    send_item(OP_TAKE, $urandom(), 2'($urandom_range(0, 3)));
    send_item(OP_SEED, start_t, ph);
    t = start_t - cfg_interval;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < take_pct) begin
        send_item(OP_TAKE, $urandom(), 2'($urandom_range(0, 3)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 99) < flip_pct) d = -d;
          case ({d > 0, ph})
            3'b1_00: ph = 2'b10;
            3'b1_10: ph = 2'b11;
            3'b1_11: ph = 2'b01;
            3'b1_01: ph = 2'b00;
            3'b0_00: ph = 2'b01;
            3'b0_01: ph = 2'b11;
            3'b0_11: ph = 2'b10;
            default: ph = 2'b00;
          endcase
          t = t + cfg_interval + $urandom_range(0, 2);
          send_item(OP_SAMPLE, t, ph);
        end else if (r < 78) begin
          // inside the interval; with a zero interval only a step back is rejected
          if (cfg_interval == 0) s = t - 1;
          else s = t + $urandom_range(0, cfg_interval - 1);
          send_item(OP_SAMPLE, s, 2'($urandom_range(0, 3)));
        end else if (r < 81) begin
          send_item(OP_SAMPLE, t - $urandom_range(1, 32'h8000_0000),
                    2'($urandom_range(0, 3)));
        end else if (r < 89) begin
          if ($urandom_range(0, 1) == 0) ph = ph ^ 2'b11;
          else ph = 2'($urandom_range(0, 3));
          t = t + cfg_interval + $urandom_range(0, 2);
          send_item(OP_SAMPLE, t, ph);
        end else if (r < 96) begin
          if (r < 93) s = t + $urandom_range(0, 50);
          else s = $urandom();
          ph = 2'($urandom_range(0, 3));
          send_item(OP_SEED, s, ph);
          t = s - cfg_interval;
        end else begin
          send_item(OpUnused, $urandom(), 2'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_cycles();
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SAMPLE;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: four quarter steps per detent, 1 ms interval
    send_item(OP_TAKE,   32'd0,         2'd0);
    send_item(OpUnused,  32'hFFFF_FFFF, 2'd3);
    send_item(OP_SAMPLE, 32'd0,         2'd2);  // no time elapsed since reset
    send_item(OP_SEED,   32'd0,         2'd0);
    send_item(OP_SAMPLE, 32'd0,         2'd1);  // exactly one interval after seed
    send_item(OP_SAMPLE, 32'd1,         2'd3);
    send_item(OP_SAMPLE, 32'd2,         2'd2);
    send_item(OP_SAMPLE, 32'd3,         2'd0);  // full detent backward
    send_item(OP_SAMPLE, 32'd3,         2'd2);  // too soon
    send_item(OP_SAMPLE, 32'd1,         2'd2);  // time went back
    send_item(OP_SAMPLE, 32'd4,         2'd2);
    send_item(OP_SAMPLE, 32'd5,         2'd3);
    send_item(OP_SAMPLE, 32'd6,         2'd1);
    send_item(OP_SAMPLE, 32'd7,         2'd0);  // full detent forward
    send_item(OP_SAMPLE, 32'd8,         2'd3);  // both phases flip: no step
    send_item(OP_SAMPLE, 32'd9,         2'd0);
    send_item(OP_SAMPLE, 32'h8000_0009, 2'd2);  // difference reads as most negative
    send_item(OP_SEED,   32'hFFFF_FFFF, 2'd0);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF, 2'd1);
    send_item(OP_SAMPLE, 32'd0,         2'd3);  // timestamp wraps
    send_item(OP_SAMPLE, 32'd1,         2'd2);
    send_item(OP_SAMPLE, 32'd2,         2'd0);
    send_item(OP_TAKE,   32'd3,         2'd0);
    send_item(OP_TAKE,   32'd4,         2'd3);

    run_phase(7'd4,   10'd1,    5,  5,  1, $urandom(),    180);
    run_phase(7'd0,   10'd0,    0,  0,  1, 32'hFFFF_FF00, 260);  // drives count to +127
    run_phase(7'd1,   10'd1023, 0,  0, -1, $urandom(),    260);  // drives count to -128
    run_phase(7'd64,  10'd7,    3,  2,  1, $urandom(),    180);
    run_phase(7'd127, 10'd2,    3,  1, -1, $urandom(),    180);
    run_phase(7'd2,   10'd1000, 8, 10,  1, $urandom(),    180);
    run_phase(7'($urandom_range(0, 127)), 10'($urandom_range(0, 1023)),
              5, 10, -1, $urandom(), 180);
    run_phase(7'($urandom_range(0, 127)), 10'($urandom_range(0, 1023)),
              5, 10,  1, $urandom(), 180);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
